// ===== rtl/srs_pkg.sv =====
`timescale 1ns / 1ps
package srs_pkg;

  localparam int WINDOW_DEF    = 6;
  localparam int SEQ_SPACE_DEF = 7;
  localparam int MSG_BYTES     = 20;
  localparam int MSG_W         = 8 * MSG_BYTES;
  localparam int BYTES_PER_STEP = 5;
  localparam int CSUM_STEPS    = MSG_BYTES / BYTES_PER_STEP;
  localparam int CSUM_CNT_W    = $clog2(CSUM_STEPS);
  localparam int TX_SEQ_W      = 3;
  localparam logic signed [1:0] ACK_UNUSED = 2'sb11;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_t;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NEW_ACK   = 3'd2,
    ST_DUP_ACK   = 3'd3,
    ST_CORRUPT   = 3'd4,
    ST_RESENT    = 3'd5,
    ST_NO_RESEND = 3'd6,
    ST_SPARE     = 3'd7
  } status_t;

  // Start request for the checksum unit.
  typedef struct packed {
    logic        start;
    logic [31:0] init;
  } csum_req_t;

endpackage

// ===== rtl/srs_if.sv =====
`timescale 1ns / 1ps
interface srs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic signed [31:0] pkt_seqnum;
  logic signed [31:0] pkt_acknum;
  logic signed [31:0] pkt_checksum;
  logic [63:0] payload_w0;
  logic [63:0] payload_w1;
  logic [31:0] payload_w2;

  modport source (output valid, opcode, pkt_seqnum, pkt_acknum, pkt_checksum,
                  payload_w0, payload_w1, payload_w2, input ready);
  modport sink (input valid, opcode, pkt_seqnum, pkt_acknum, pkt_checksum,
                payload_w0, payload_w1, payload_w2, output ready);
endinterface

interface srs_out_if;
  logic        valid;
  logic        ready;
  logic        transmit;
  logic [2:0]  tx_seqnum;
  logic signed [1:0]  tx_acknum;
  logic signed [31:0] tx_checksum;
  logic [63:0] tx_word0;
  logic [63:0] tx_word1;
  logic [31:0] tx_word2;
  logic [1:0]  timer_cmd;
  logic [2:0]  status;

  modport source (output valid, transmit, tx_seqnum, tx_acknum, tx_checksum,
                  tx_word0, tx_word1, tx_word2, timer_cmd, status, input ready);
  modport sink (input valid, transmit, tx_seqnum, tx_acknum, tx_checksum,
                tx_word0, tx_word1, tx_word2, timer_cmd, status, output ready);
endinterface

// ===== rtl/selective_repeat_sender.sv =====
`timescale 1ns / 1ps
// Selective-repeat ARQ sender with one retransmission timer.
// The input channel carries one command per transfer: a message to send, an
// arrived ACK packet, or a timer expiry. The output channel returns exactly
// one result per command (a reserved opcode is dropped with no result).
// A send starts the checksum unit at its transfer: the unit adds five message
// bytes per cycle, then the block sees it finish and loads the result.
// A send into a full window goes straight to its result, with no checksum.
// An ACK is checksummed first, and an intact one is then matched against the
// window slots; an ACK at the head then slides the window past each acked slot.
// A timeout that resends scans for the first unacked slot, reads its stored
// packet and checksums it; with nothing to resend it scans every slot in the
// window. The block works on one command at a time and is ready only when
// idle, in the cycle after the previous result is loaded.
// Reset (synchronous, active high) empties the window, clears all acked
// flags and restarts sequence numbering at zero; stored packets need no
// clearing. If the receiver stalls, the finished result waits in the output
// register, and the block may still take the next command; a second result
// waits inside until the output register is free.
module selective_repeat_sender #(
  parameter int WINDOW    = srs_pkg::WINDOW_DEF,
  parameter int SEQ_SPACE = srs_pkg::SEQ_SPACE_DEF
) (
  input logic clk,
  input logic rst,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch
);
  import srs_pkg::*;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SEQ_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SLIDE = 6'b001000,
    S_LOAD  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state;
  op_t    op;

  // Window bookkeeping.
  logic [IDX_W-1:0]  head;
  logic [FILL_W-1:0] fill;
  logic [SEQ_W-1:0]  next_seq;
  logic [WINDOW-1:0] acked;
  logic [SEQ_W-1:0]  slot_seq [WINDOW];

  // Packet store: one 160-bit row per slot, registered read.
  logic [MSG_W-1:0] slot_mem [WINDOW];
  logic [MSG_W-1:0] mem_rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] scan_k;
  logic [FILL_W-1:0] scan_i;

  // Latched command fields.
  logic [31:0]      ack_num;
  logic [31:0]      ack_ck;
  logic [MSG_W-1:0] pay;

  // Result being built.
  logic        r_tx;
  logic [SEQ_W-1:0] r_seq;
  logic [31:0] r_ck;
  timer_t      r_timer;
  status_t     r_status;

  csum_req_t   csum_req;
  logic        csum_done;
  logic [31:0] csum_sum;
  logic [MSG_W-1:0] csum_data;

  logic [IDX_W+1:0] tail_sum;
  logic [IDX_W-1:0] tail_slot;
  logic             accept;
  logic             out_free;
  logic [IDX_W-1:0] k_inc;
  logic [IDX_W-1:0] head_inc;
  logic [31:0]      seq_at_k;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign tail_sum  = (IDX_W + 2)'(head) + (IDX_W + 2)'(fill);
  assign tail_slot = (tail_sum >= (IDX_W + 2)'(WINDOW)) ?
                     IDX_W'(tail_sum - (IDX_W + 2)'(WINDOW)) : IDX_W'(tail_sum);
  assign k_inc    = (scan_k == IDX_W'(WINDOW - 1)) ? '0 : scan_k + 1'b1;
  assign head_inc = (head == IDX_W'(WINDOW - 1)) ? '0 : head + 1'b1;
  assign seq_at_k = 32'(slot_seq[scan_k]);

  assign mem_we    = accept && (op_t'(in_ch.opcode) == OP_SEND) &&
                     (fill != FILL_W'(WINDOW));
  assign mem_waddr = tail_slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= {in_ch.payload_w2, in_ch.payload_w1, in_ch.payload_w0};
      slot_seq[mem_waddr] <= next_seq;
    end
    mem_rdata <= slot_mem[scan_k];
  end

  // Checksum start: sends into a window with room begin at the transfer, ACKs
  // too; resends start once the stored packet has been read.
  always_comb begin
    csum_req.start = 1'b0;
    csum_req.init  = '0;
    csum_data      = {in_ch.payload_w2, in_ch.payload_w1, in_ch.payload_w0};
    if (accept && (op_t'(in_ch.opcode) == OP_SEND)) begin
      csum_req.start = (fill != FILL_W'(WINDOW));
      csum_req.init  = 32'(next_seq) + 32'hFFFF_FFFF;
    end else if (accept && (op_t'(in_ch.opcode) == OP_ACK)) begin
      csum_req.start = 1'b1;
      csum_req.init  = in_ch.pkt_seqnum + in_ch.pkt_acknum;
    end else if (state == S_LOAD) begin
      csum_req.start = 1'b1;
      csum_req.init  = 32'(r_seq) + 32'hFFFF_FFFF;
      csum_data      = mem_rdata;
    end
  end

  srs_csum u_csum (
    .clk  (clk),
    .rst  (rst),
    .req  (csum_req),
    .data (csum_data),
    .done (csum_done),
    .sum  (csum_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      fill     <= '0;
      next_seq <= '0;
      acked    <= '0;
      op       <= OP_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= op_t'(in_ch.opcode);
            unique case (op_t'(in_ch.opcode))
              OP_SEND: begin
                if (fill == FILL_W'(WINDOW)) begin
                  state <= S_FIN;
                end else begin
                  acked[tail_slot] <= 1'b0;
                  fill  <= fill + 1'b1;
                  next_seq <= (next_seq == SEQ_W'(SEQ_SPACE - 1)) ?
                              '0 : next_seq + 1'b1;
                  state <= S_SUM;
                end
              end
              OP_ACK:     state <= S_SUM;
              OP_TIMEOUT: state <= S_SCAN;
              OP_NONE:    state <= S_IDLE;
            endcase
          end
        end
        S_SUM: begin
          if (csum_done) begin
            if (op == OP_ACK && csum_sum == ack_ck) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (scan_i == fill) begin
            state <= S_FIN;
          end else if (op == OP_ACK) begin
            if (seq_at_k == ack_num) begin
              if (acked[scan_k]) begin
                state <= S_FIN;
              end else begin
                acked[scan_k] <= 1'b1;
                state <= (scan_k == head) ? S_SLIDE : S_FIN;
              end
            end
          end else if (!acked[scan_k]) begin
            state <= S_LOAD;
          end
        end
        S_SLIDE: begin
          if (fill != '0 && acked[head]) begin
            head <= head_inc;
            fill <= fill - 1'b1;
          end else begin
            state <= S_FIN;
          end
        end
        S_LOAD: state <= S_SUM;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan pointer and result fields.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan_i <= '0;
      scan_k <= head;
    end else if (state == S_SCAN) begin
      scan_i <= scan_i + 1'b1;
      scan_k <= k_inc;
    end
    if (accept) begin
      ack_num  <= in_ch.pkt_acknum;
      ack_ck   <= in_ch.pkt_checksum;
      pay      <= {in_ch.payload_w2, in_ch.payload_w1, in_ch.payload_w0};
      r_tx     <= 1'b0;
      r_seq    <= next_seq;
      r_ck     <= '0;
      r_timer  <= TMR_NONE;
      r_status <= ST_FULL;
    end
    unique case (state)
      S_SUM: begin
        if (csum_done) begin
          if (op == OP_SEND) begin
            r_tx     <= 1'b1;
            r_ck     <= csum_sum;
            r_status <= ST_SENT;
            r_timer  <= (fill == FILL_W'(1)) ? TMR_START : TMR_NONE;
          end else if (op == OP_TIMEOUT) begin
            r_tx     <= 1'b1;
            r_ck     <= csum_sum;
            r_status <= ST_RESENT;
            r_timer  <= TMR_START;
          end else if (csum_sum != ack_ck) begin
            r_status <= ST_CORRUPT;
          end
        end
      end
      S_SCAN: begin
        if (scan_i == fill) begin
          r_status <= (op == OP_ACK) ? ST_DUP_ACK : ST_NO_RESEND;
          r_timer  <= (op == OP_ACK) ? TMR_NONE : TMR_START;
        end else if (op == OP_ACK) begin
          if (seq_at_k == ack_num) begin
            r_status <= acked[scan_k] ? ST_DUP_ACK : ST_NEW_ACK;
          end
        end else if (!acked[scan_k]) begin
          r_seq <= slot_seq[scan_k];
        end
      end
      S_SLIDE: begin
        if (!(fill != '0 && acked[head])) begin
          r_timer <= (fill != '0) ? TMR_RESTART : TMR_STOP;
        end
      end
      S_LOAD: pay <= mem_rdata;
      S_IDLE, S_FIN: ;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_ch.transmit    <= r_tx;
      out_ch.tx_seqnum   <= r_tx ? TX_SEQ_W'(32'(r_seq)) : '0;
      out_ch.tx_checksum <= r_ck;
      out_ch.tx_word0    <= r_tx ? pay[63:0] : '0;
      out_ch.tx_word1    <= r_tx ? pay[127:64] : '0;
      out_ch.tx_word2    <= r_tx ? pay[159:128] : '0;
      out_ch.timer_cmd   <= r_timer;
      out_ch.status      <= r_status;
    end
  end

  assign out_ch.tx_acknum = ACK_UNUSED;

  // The window never holds more packets than it has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("window fill exceeds window size");

  // A reserved opcode produces no work.
  a_no_op: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.opcode == OP_NONE) |=> (state == S_IDLE))
    else $error("reserved opcode started work");

  // The checksum unit finishes only while a command waits for it.
  a_csum_done: assert property (@(posedge clk) disable iff (rst)
    csum_done |-> (state == S_SUM))
    else $error("checksum finished outside the sum state");

  // A result is loaded only when the output register is free.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready && state == S_FIN) |=> (state == S_FIN))
    else $error("result left while output stalled");

endmodule

// ===== rtl/srs_csum.sv =====
`timescale 1ns / 1ps
// Iterative checksum: adds five sign-extended message bytes per cycle.
module srs_csum (
  input  logic              clk,
  input  logic              rst,
  input  srs_pkg::csum_req_t req,
  input  logic [srs_pkg::MSG_W-1:0] data,
  output logic              done,
  output logic [31:0]       sum
);
  import srs_pkg::*;

  logic [MSG_W-1:0]      buf_q;
  logic [CSUM_CNT_W-1:0] cnt;
  logic                  busy;
  logic [31:0]           step_sum;

  always_comb begin
    step_sum = sum;
    for (int b = 0; b < BYTES_PER_STEP; b++) begin
      step_sum = step_sum + {{24{buf_q[8*b+7]}}, buf_q[8*b +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CSUM_CNT_W'(CSUM_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CSUM_CNT_W'(CSUM_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      buf_q <= data;
      sum   <= req.init;
    end else if (busy) begin
      buf_q <= buf_q >> (8 * BYTES_PER_STEP);
      sum   <= step_sum;
    end
  end

endmodule
